// ===== sv/rlpi_pkg.sv =====
// Package for the raster and light-pen interrupt unit.
// Holds the shared types, command and register codes, and revision decode functions.
// No dependencies.
`timescale 1ns / 1ps

package rlpi_pkg;

    // Command codes carried by an input word.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_LATCH = 2'd2,
        CMD_ACK   = 2'd3
    } cmd_t;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_REVISION = 2'd0;
    localparam logic [1:0] REG_COMPARE  = 2'd1;
    localparam logic [1:0] REG_MASK     = 2'd2;

    // Chip revisions.
    localparam logic [2:0] REV_PAL_R1     = 3'd0;
    localparam logic [2:0] REV_PAL_8565   = 3'd2;
    localparam logic [2:0] REV_NTSC_6567  = 3'd3;
    localparam logic [2:0] REV_NTSC_R56A  = 3'd4;
    localparam logic [2:0] REV_NTSC_8562  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [2:0] REVISION_RESET = REV_PAL_8565;
    localparam logic [8:0] COMPARE_RESET  = 9'd0;
    localparam logic [3:0] MASK_RESET     = 4'd0;

    // Beam position constants.
    localparam logic [8:0] PEN_LINE_LAST  = 9'd311;
    localparam logic [6:0] PEN_CYCLE_WRAP = 7'd14;
    localparam logic [6:0] PEN_CYCLE_ONE  = 7'd1;
    localparam logic [9:0] X_BASE_PAL     = 10'd392;
    localparam logic [9:0] X_BASE_NTSC    = 10'd400;
    localparam logic [7:0] FRAME_X_PAL    = 8'd209;
    localparam logic [7:0] FRAME_X_NTSC   = 8'd213;

    // Flag bit positions.
    localparam int unsigned FLAG_RASTER = 0;
    localparam int unsigned FLAG_PEN    = 3;

    typedef struct packed {
        logic [2:0] revision;
        logic [8:0] compare_line;
        logic [3:0] enable_mask;
    } cfg_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [6:0] raster_cycle;
        logic [8:0] line_counter;
        logic       pen_level;
        logic [3:0] ack_bits;
    } item_t;

    typedef struct packed {
        logic [3:0] pending_flags;
        logic       irq_active;
        logic [7:0] pen_x;
        logic [8:0] pen_y;
    } result_t;

    // Revision codes above the NTSC 8562 act as the PAL 8565.
    function automatic logic [2:0] eff_rev(input logic [2:0] rev);
        return (rev > REV_NTSC_8562) ? REV_PAL_8565 : rev;
    endfunction

    function automatic logic is_ntsc(input logic [2:0] rev);
        return eff_rev(rev) >= REV_NTSC_6567;
    endfunction

    // Cycles per raster line.
    function automatic logic [6:0] line_len(input logic [2:0] rev);
        logic [2:0] r;
        r = eff_rev(rev);
        if (r == REV_NTSC_R56A) return 7'd64;
        if (r == REV_NTSC_6567 || r == REV_NTSC_8562) return 7'd65;
        return 7'd63;
    endfunction

    // Light-pen X offset of the revision.
    function automatic logic [9:0] pen_offset(input logic [2:0] rev);
        logic [2:0] r;
        r = eff_rev(rev);
        return (r == REV_PAL_8565 || r == REV_NTSC_8562) ? 10'd2 : 10'd4;
    endfunction

endpackage

// ===== sv/rlpi_apb_regs.sv =====
// APB configuration registers of the raster and light-pen interrupt unit.
// Depends on rlpi_pkg.
`timescale 1ns / 1ps

module rlpi_apb_regs
    import rlpi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register write decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_REVISION: cfg_next.revision     = pwdata[2:0];
                REG_COMPARE:  cfg_next.compare_line = pwdata[8:0];
                REG_MASK:     cfg_next.enable_mask  = pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.revision     <= REVISION_RESET;
            cfg_reg.compare_line <= COMPARE_RESET;
            cfg_reg.enable_mask  <= MASK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read data mux.
    always_comb begin
        unique case (reg_idx)
            REG_REVISION: prdata = {29'd0, cfg_reg.revision};
            REG_COMPARE:  prdata = {23'd0, cfg_reg.compare_line};
            REG_MASK:     prdata = {28'd0, cfg_reg.enable_mask};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/rlpi_core.sv =====
// Interrupt state and per-word evaluation of the raster and light-pen unit.
// Depends on rlpi_pkg.
`timescale 1ns / 1ps

module rlpi_core
    import rlpi_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    advance,
    output result_t result
);

    logic       match_prev_reg, match_prev_next;
    logic [3:0] flag_reg, flag_next;
    logic       pen_prev_reg, pen_prev_next;
    logic       pen_done_reg, pen_done_next;
    logic [7:0] pen_x_reg, pen_x_next;
    logic [8:0] pen_y_reg, pen_y_next;

    logic [9:0]  cmp_val;
    logic        match;
    logic        pen_event;
    logic [9:0]  beam_pos;
    logic [10:0] beam_x;
    logic [2:0]  rev;

    assign rev = eff_rev(cfg.revision);

    // Raster compare: in the last cycle of a line the next line is used.
    assign cmp_val = {1'b0, item.line_counter}
                   + {9'd0, (item.raster_cycle >= line_len(cfg.revision))};
    assign match   = (cmp_val == {1'b0, cfg.compare_line});

    // Falling pen edge, once per frame, not on the last line except in cycle one.
    assign pen_event = pen_prev_reg && !item.pen_level && !pen_done_reg
                    && !(item.line_counter == PEN_LINE_LAST
                         && item.raster_cycle != PEN_CYCLE_ONE);

    // Beam X position of the pen event.
    always_comb begin
        if (item.raster_cycle < PEN_CYCLE_WRAP) begin
            beam_pos = (is_ntsc(cfg.revision) ? X_BASE_NTSC : X_BASE_PAL)
                     + {item.raster_cycle, 3'd0};
        end else begin
            beam_pos = {item.raster_cycle - PEN_CYCLE_WRAP, 3'd0};
        end
    end
    assign beam_x = {1'b0, beam_pos} + {1'b0, pen_offset(cfg.revision)};

    // Next state for one word.
    always_comb begin
        match_prev_next = match_prev_reg;
        flag_next       = flag_reg;
        pen_prev_next   = pen_prev_reg;
        pen_done_next   = pen_done_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        unique case (item.cmd)
            CMD_TICK: begin
                if (match && !match_prev_reg) flag_next[FLAG_RASTER] = 1'b1;
                match_prev_next = match;
                if (pen_event) begin
                    pen_x_next    = beam_x[8:1];
                    pen_y_next    = item.line_counter;
                    pen_done_next = 1'b1;
                    if (rev != REV_PAL_R1 && rev != REV_NTSC_R56A) begin
                        flag_next[FLAG_PEN] = 1'b1;
                    end
                end
                pen_prev_next = item.pen_level;
            end
            CMD_FRAME: begin
                pen_done_next = 1'b0;
            end
            CMD_LATCH: begin
                pen_x_next          = is_ntsc(cfg.revision) ? FRAME_X_NTSC : FRAME_X_PAL;
                pen_y_next          = 9'd0;
                flag_next[FLAG_PEN] = 1'b1;
                pen_done_next       = 1'b1;
            end
            CMD_ACK: begin
                flag_next = flag_reg & ~item.ack_bits;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_prev_reg <= 1'b0;
            flag_reg       <= 4'd0;
            pen_prev_reg   <= 1'b1;
            pen_done_reg   <= 1'b0;
            pen_x_reg      <= 8'd0;
            pen_y_reg      <= 9'd0;
        end else if (advance) begin
            match_prev_reg <= match_prev_next;
            flag_reg       <= flag_next;
            pen_prev_reg   <= pen_prev_next;
            pen_done_reg   <= pen_done_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
        end
    end

    // Result of the word being evaluated.
    assign result.pending_flags = flag_next;
    assign result.irq_active    = |(flag_next & cfg.enable_mask);
    assign result.pen_x         = pen_x_next;
    assign result.pen_y         = pen_y_next;

`ifndef ASSERT_OFF
    a_frame_clears_done: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.cmd == CMD_FRAME |=> !pen_done_reg)
        else $error("begin frame did not clear the pen latch lock");

    a_ack_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.cmd == CMD_ACK |=> (flag_reg & $past(item.ack_bits)) == 4'd0)
        else $error("acknowledged flags still pending");

    a_latch_sets_pen: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.cmd == CMD_LATCH |=> flag_reg[FLAG_PEN] && pen_done_reg
                                          && pen_y_reg == 9'd0)
        else $error("frame-start latch did not set the pen state");

    a_pen_prev_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.cmd != CMD_TICK |=> $stable(pen_prev_reg) && $stable(match_prev_reg))
        else $error("edge history changed on a non-tick command");
`endif

endmodule

// ===== sv/raster_lightpen_interrupt_unit_top.sv =====
// Top level of the raster and light-pen interrupt unit.
// Depends on rlpi_pkg, rlpi_apb_regs and rlpi_core.
`timescale 1ns / 1ps

// Usage:
// The input channel (s_valid/s_ready) takes one word per emulated video cycle:
// a command, the raster cycle and line, the light pen level and acknowledge bits.
// The result channel (m_valid/m_ready) returns one word per input word: the
// pending flags, the masked IRQ line and the latched pen coordinates.
// A word is captured in an input register, evaluated in one pass against the
// interrupt state, and its result lands in an output register, which drives
// m_valid. One word per cycle is sustained while the receiver keeps m_ready
// high; the state update between the two registers sets that figure.
// When the receiver stalls, the result waits in the output register while the
// input register still takes one more word; s_ready then drops until m_ready.
// The APB port writes revision (0x0), raster compare line (0x4) and IRQ enable
// mask (0x8); write only while the block is idle.
// Reset (aresetn low, synchronous) empties both registers, clears all flags
// and latches, marks the pen released and restores the register defaults.
module raster_lightpen_interrupt_unit_top
    import rlpi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [6:0]  s_raster_cycle,
    input  logic [8:0]  s_line_counter,
    input  logic        s_pen_level,
    input  logic [3:0]  s_ack_bits,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_pending_flags,
    output logic        m_irq_active,
    output logic [7:0]  m_pen_x,
    output logic [8:0]  m_pen_y
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    rlpi_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The stored word moves on when the output register is free or being read.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.cmd          <= cmd_t'(s_cmd);
            item_reg.raster_cycle <= s_raster_cycle;
            item_reg.line_counter <= s_line_counter;
            item_reg.pen_level    <= s_pen_level;
            item_reg.ack_bits     <= s_ack_bits;
        end
    end

    rlpi_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .result  (res_next)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pending_flags = res_reg.pending_flags;
    assign m_irq_active    = res_reg.irq_active;
    assign m_pen_x         = res_reg.pen_x;
    assign m_pen_y         = res_reg.pen_y;

endmodule
